### hdl/rfd_pkg.sv
// Shared types and constants for the reply frame deframer.
// No dependencies; used by every module under hdl/.
`default_nettype none

package rfd_pkg;

   localparam int MAX_DATA   = 64;
   localparam int MIN_FRAME  = 6;
   localparam int DATA_START = 4;
   localparam int CNT_W      = 7;
   localparam int POS_W      = 8;
   localparam int CSR_AW     = 4;

   localparam logic [CSR_AW-3:0] REG_HEAD = 2'd0;
   localparam logic [CSR_AW-3:0] REG_TAIL = 2'd1;
   localparam logic [CSR_AW-3:0] REG_ACK  = 2'd2;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SHORT    = 3'd1,
      ST_BAD_HEAD = 3'd2,
      ST_BAD_TAIL = 3'd3,
      ST_BAD_SUM  = 3'd4,
      ST_DEV_ERR  = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] head_value;
      logic [7:0] tail_value;
      logic [7:0] ack_ok_value;
   } cfg_type;

   typedef struct packed {
      logic             kind;
      logic [7:0]       data_byte;
      logic [7:0]       addr;
      logic [7:0]       code;
      logic [7:0]       err_byte;
      logic [CNT_W-1:0] data_count;
      status_type       status;
   } rsp_type;

endpackage

`default_nettype wire

### hdl/rfd_csr.sv
// Configuration registers behind the APB-style port.
// Depends on rfd_pkg.
`default_nettype none

module rfd_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [rfd_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic      [31:0]                csr_prdata,
   output logic                            csr_pready,
   output rfd_pkg::cfg_type                cfg
);

   rfd_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [rfd_pkg::CSR_AW-3:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = csr_paddr[rfd_pkg::CSR_AW-1:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            rfd_pkg::REG_HEAD: cfg_in.head_value   = csr_pwdata[7:0];
            rfd_pkg::REG_TAIL: cfg_in.tail_value   = csr_pwdata[7:0];
            rfd_pkg::REG_ACK:  cfg_in.ack_ok_value = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         rfd_pkg::REG_HEAD: csr_prdata = {24'd0, cfg_ff.head_value};
         rfd_pkg::REG_TAIL: csr_prdata = {24'd0, cfg_ff.tail_value};
         rfd_pkg::REG_ACK:  csr_prdata = {24'd0, cfg_ff.ack_ok_value};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### hdl/rfd_tracker.sv
// Frame state: position, running sum, held byte, header fields, payload count.
// Builds a data word for each payload byte it releases, or the verdict at end of frame. Depends on rfd_pkg.
`default_nettype none

module rfd_tracker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       rx_byte,
   input  wire logic             end_of_frame,
   input  wire rfd_pkg::cfg_type cfg,
   output logic                  push,
   output rfd_pkg::rsp_type      rsp
);

   logic [rfd_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0]                sum_ff, sum_in;
   logic [7:0]                held_ff, held_in;
   logic                      head_ok_ff, head_ok_in;
   logic [7:0]                addr_ff, addr_in;
   logic [7:0]                code_ff, code_in;
   logic [7:0]                err_ff, err_in;
   logic [rfd_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      is_data;
   rfd_pkg::status_type       st;

   always_comb begin
      head_ok_in = head_ok_ff;
      addr_in    = addr_ff;
      code_in    = code_ff;
      err_in     = err_ff;
      case (pos_ff)
         8'd0:    head_ok_in = (rx_byte == cfg.head_value);
         8'd1:    addr_in    = rx_byte;
         8'd2:    code_in    = rx_byte;
         8'd3:    err_in     = rx_byte;
         default: ;
      endcase

      if (pos_ff < rfd_pkg::POS_W'(rfd_pkg::MIN_FRAME - 1))  st = rfd_pkg::ST_SHORT;
      else if (!head_ok_in)                               st = rfd_pkg::ST_BAD_HEAD;
      else if (rx_byte != cfg.tail_value)                 st = rfd_pkg::ST_BAD_TAIL;
      else if (held_ff != sum_ff)                         st = rfd_pkg::ST_BAD_SUM;
      else if (err_in != cfg.ack_ok_value)                st = rfd_pkg::ST_DEV_ERR;
      else                                                st = rfd_pkg::ST_OK;

      is_data = (pos_ff >= rfd_pkg::POS_W'(rfd_pkg::DATA_START + 1)) &&
                (cnt_ff < rfd_pkg::CNT_W'(rfd_pkg::MAX_DATA));

      rsp = '0;
      if (end_of_frame) begin
         rsp.kind       = 1'b1;
         rsp.addr       = addr_in;
         rsp.code       = code_in;
         rsp.err_byte   = err_in;
         rsp.data_count = cnt_ff;
         rsp.status     = st;
      end else begin
         rsp.data_byte  = held_ff;
      end
      push = accept && (end_of_frame || is_data);

      pos_in  = pos_ff;
      sum_in  = sum_ff;
      held_in = held_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         if (end_of_frame) begin
            pos_in     = '0;
            sum_in     = '0;
            held_in    = '0;
            cnt_in     = '0;
            head_ok_in = 1'b0;
            addr_in    = '0;
            code_in    = '0;
            err_in     = '0;
         end else begin
            if (is_data)        cnt_in = cnt_ff + 1'b1;
            if (pos_ff != '0)   sum_in = sum_ff + held_ff;
            held_in = rx_byte;
            if (pos_ff != '1)   pos_in = pos_ff + 1'b1;
         end
      end else begin
         head_ok_in = head_ok_ff;
         addr_in    = addr_ff;
         code_in    = code_ff;
         err_in     = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         sum_ff     <= '0;
         held_ff    <= '0;
         head_ok_ff <= 1'b0;
         addr_ff    <= '0;
         code_ff    <= '0;
         err_ff     <= '0;
         cnt_ff     <= '0;
      end else begin
         pos_ff     <= pos_in;
         sum_ff     <= sum_in;
         held_ff    <= held_in;
         head_ok_ff <= head_ok_in;
         addr_ff    <= addr_in;
         code_ff    <= code_in;
         err_ff     <= err_in;
         cnt_ff     <= cnt_in;
      end
   end

endmodule

`default_nettype wire

### hdl/rfd_skid.sv
// Result register with a skid stage; ready toward the input is registered.
// Depends on rfd_pkg.
`default_nettype none

module rfd_skid (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire rfd_pkg::rsp_type push_data,
   output logic                  in_ready,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output rfd_pkg::rsp_type      out_data
);

   logic             main_vld_ff, main_vld_in;
   logic             skid_vld_ff, skid_vld_in;
   rfd_pkg::rsp_type main_ff, main_in;
   rfd_pkg::rsp_type skid_ff, skid_in;
   logic             pop;

   assign in_ready  = !skid_vld_ff;
   assign out_valid = main_vld_ff;
   assign out_data  = main_ff;
   assign pop       = main_vld_ff && out_ready;

   always_comb begin
      main_vld_in = main_vld_ff;
      skid_vld_in = skid_vld_ff;
      main_in     = main_ff;
      skid_in     = skid_ff;
      if (pop) begin
         if (skid_vld_ff) begin
            main_in     = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            main_in     = push_data;
            main_vld_in = push;
         end
      end else if (!main_vld_ff) begin
         main_in     = push_data;
         main_vld_in = push;
      end else if (push) begin
         skid_in     = push_data;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

### hdl/reply_frame_deframer.sv
// Reply frame deframer top level: config registers, frame tracker, result buffer.
// Result words are registered in the main slot of the result buffer, or in its skid slot.
// Throughput: one byte per cycle; req_tready drops only while both result slots are full.
// Reset (synchronous, active high) clears registers, frame state and the result buffer.
// Depends on rfd_pkg, rfd_csr, rfd_tracker, rfd_skid.
`default_nettype none

module reply_frame_deframer (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [7:0]                 req_tdata,   // rx_byte
   input  wire logic                       req_tlast,   // end_of_frame
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [47:0]                rsp_tdata,   // data_byte, addr, code, err_byte,
                                                        // data_count[6:0], status[2:0], zeros
   output logic                            rsp_tuser,   // kind
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [rfd_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic      [31:0]                csr_prdata,
   output logic                            csr_pready
);

   rfd_pkg::cfg_type cfg;
   rfd_pkg::rsp_type push_data;
   rfd_pkg::rsp_type out_data;
   logic             push;
   logic             accept;

   assign accept = req_tvalid && req_tready;

   rfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rfd_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_tdata),
      .end_of_frame (req_tlast),
      .cfg          (cfg),
      .push         (push),
      .rsp          (push_data)
   );

   rfd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tuser = out_data.kind;
   assign rsp_tdata = {6'd0, out_data.status, out_data.data_count, out_data.err_byte,
                       out_data.code, out_data.addr, out_data.data_byte};

`ifndef SYNTH
   a_full_has_output: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("buffer full without a valid output");

   a_data_word_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[47:8] == 40'd0)
      else $error("data word carries verdict fields");

   a_verdict_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[7:0] == 8'd0 && rsp_tdata[38:32] <= 7'(rfd_pkg::MAX_DATA))
      else $error("verdict has data byte or count above limit");
`endif

endmodule

`default_nettype wire

### tb/tb_reply_frame_deframer.sv
// Testbench for reply_frame_deframer: random reply frames (good, flawed, short, overlong)
// are streamed in and every data and verdict word is checked against an in-bench predictor.
// Depends on rfd_pkg and the RTL under hdl/.
module tb_reply_frame_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0] frame_type[$];
   typedef enum int {
      FLAW_NONE, FLAW_HEAD, FLAW_TAIL, FLAW_SUM, FLAW_DEV, FLAW_NOISE
   } flaw_type;

   localparam logic [rfd_pkg::CSR_AW-3:0] REG_SPARE = 2'd3;
   localparam int IDLE_PCT     = 18;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_BYTES = 350;
   localparam int MAX_REPORTS  = 10;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_tvalid  = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata   = '0;   // rx_byte
   logic                       req_tlast   = 1'b0; // end_of_frame
   logic                       rsp_tvalid;
   logic                       rsp_tready  = 1'b0;
   logic [47:0]                rsp_tdata;   // data_byte, addr, code, err_byte, data_count, status
   logic                       rsp_tuser;   // kind
   logic                       csr_psel    = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite  = 1'b0;
   logic [rfd_pkg::CSR_AW-1:0] csr_paddr   = '0;
   logic [31:0]                csr_pwdata  = '0;
   logic [31:0]                csr_prdata;
   logic                       csr_pready;

   // predictor copy of registers and frame state
   logic [7:0] head_reg = '0, tail_reg = '0, ack_reg = '0;
   logic [7:0] frame_pos = '0, frame_sum = '0, held_byte = '0;
   logic [7:0] got_addr = '0, got_code = '0, got_err = '0;
   logic       head_seen = 1'b0;
   logic [6:0] payload_sent = '0;
   rfd_pkg::rsp_type deframed_words[$];

   int mismatches   = 0;
   int bytes_sent   = 0;
   bit calm         = 1'b0;
   bit hold_pending = 1'b0;

   reply_frame_deframer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic void report_mismatch(input string what, input logic [63:0] want,
                                           input logic [63:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch %s: expected %0h, got %0h", what, want, got);
   endfunction

   function automatic void deframe_byte(input logic [7:0] b, input logic eof);
      rfd_pkg::rsp_type w;
      w = '0;
      w.status = rfd_pkg::ST_OK;
      case (frame_pos)
         8'd0: head_seen = (b == head_reg);
         8'd1: got_addr = b;
         8'd2: got_code = b;
         8'd3: got_err = b;
         default: ;
      endcase
      if (eof) begin
         w.kind = 1'b1;
         w.addr = got_addr;
         w.code = got_code;
         w.err_byte = got_err;
         w.data_count = payload_sent;
         if (frame_pos < rfd_pkg::MIN_FRAME - 1) w.status = rfd_pkg::ST_SHORT;
         else if (!head_seen) w.status = rfd_pkg::ST_BAD_HEAD;
         else if (b != tail_reg) w.status = rfd_pkg::ST_BAD_TAIL;
         else if (held_byte != frame_sum) w.status = rfd_pkg::ST_BAD_SUM;
         else if (got_err != ack_reg) w.status = rfd_pkg::ST_DEV_ERR;
         deframed_words.push_back(w);
         frame_pos = '0;
         frame_sum = '0;
         held_byte = '0;
         head_seen = 1'b0;
         got_addr = '0;
         got_code = '0;
         got_err = '0;
         payload_sent = '0;
      end else begin
         // the held byte is payload once it sits at position DATA_START or later
         if (frame_pos >= rfd_pkg::DATA_START + 1 && payload_sent < rfd_pkg::MAX_DATA) begin
            w.data_byte = held_byte;
            deframed_words.push_back(w);
            payload_sent++;
         end
         if (frame_pos != 8'd0) frame_sum += held_byte;
         held_byte = b;
         if (frame_pos != 8'hFF) frame_pos++;
      end
   endfunction

   function automatic frame_type build_frame(input int n, input flaw_type flaw);
      frame_type  f;
      logic [7:0] sum;
      logic [7:0] nz;
      nz = 8'($urandom_range(255, 1));
      if (flaw == FLAW_NOISE) begin
         // n random bytes; half the time the head matches so later checks are reached
         repeat (n) f.push_back(8'($urandom));
         if ($urandom_range(1)) f[0] = head_reg;
         return f;
      end
      f.push_back(flaw == FLAW_HEAD ? head_reg ^ nz : head_reg);
      f.push_back(8'($urandom));
      f.push_back(8'($urandom));
      f.push_back(flaw == FLAW_DEV ? ack_reg ^ nz : ack_reg);
      repeat (n) f.push_back(8'($urandom));
      sum = '0;
      foreach (f[i]) sum += f[i];
      f.push_back(flaw == FLAW_SUM ? sum ^ nz : sum);
      f.push_back(flaw == FLAW_TAIL ? tail_reg ^ nz : tail_reg);
      return f;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eof);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eof;
      do @(posedge clock); while (!req_tready);
      deframe_byte(b, eof);
      bytes_sent++;
   endtask

   task automatic send_frame(input frame_type f);
      foreach (f[i]) send_byte(f[i], i == f.size() - 1);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (deframed_words.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [rfd_pkg::CSR_AW-3:0] idx, input logic [7:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'($urandom), v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         rfd_pkg::REG_HEAD: head_reg = v;
         rfd_pkg::REG_TAIL: tail_reg = v;
         rfd_pkg::REG_ACK:  ack_reg = v;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [rfd_pkg::CSR_AW-3:0] idx, input logic [7:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[7:0] !== want) report_mismatch("register read", want, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [7:0] h, input logic [7:0] t, input logic [7:0] a);
      wait_idle();
      csr_write(rfd_pkg::REG_HEAD, h);
      csr_write(rfd_pkg::REG_TAIL, t);
      csr_write(rfd_pkg::REG_ACK, a);
      csr_write(REG_SPARE, 8'($urandom));
      csr_read(rfd_pkg::REG_HEAD, h);
      csr_read(rfd_pkg::REG_TAIL, t);
      csr_read(rfd_pkg::REG_ACK, a);
   endtask

   task automatic test_registers();
      csr_read(rfd_pkg::REG_HEAD, 8'h00);
      csr_read(rfd_pkg::REG_TAIL, 8'h00);
      csr_read(rfd_pkg::REG_ACK, 8'h00);
      program_regs(8'hFF, 8'h00, 8'hFF);
   endtask

   task automatic test_frame_status();
      send_frame(build_frame(0, FLAW_NONE));
      send_frame(build_frame(0, FLAW_DEV));
      send_frame(build_frame(1, FLAW_SUM));
      send_frame(build_frame(0, FLAW_TAIL));
      send_frame(build_frame(0, FLAW_HEAD));
      send_frame(build_frame(1, FLAW_NOISE));
      send_frame(build_frame(5, FLAW_NOISE));
   endtask

   task automatic test_overlong();
      program_regs(8'h00, 8'hFF, 8'h00);
      send_frame(build_frame(rfd_pkg::MAX_DATA + 3, FLAW_NONE));
      // long enough for the position count to saturate
      send_frame(build_frame(254, FLAW_NONE));
   endtask

   task automatic test_backpressure();
      hold_pending = 1'b1;
      send_frame(build_frame(24, FLAW_NONE));
   endtask

   task automatic test_random();
      int start, progress, next_cfg, cfg_step, r;
      start    = bytes_sent;
      next_cfg = 0;
      cfg_step = 0;
      progress = 0;
      while (progress < RANDOM_BYTES) begin
         if (progress >= next_cfg) begin
            next_cfg += 150;
            case (cfg_step % 3)
               0: program_regs(8'h00, 8'hFF, 8'h00);
               1: program_regs(8'hFF, 8'h00, 8'hFF);
               default: program_regs(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            cfg_step++;
         end
         calm = (progress >= 150 && progress < 270);
         r = $urandom_range(99);
         if (r < 55)
            send_frame(build_frame($urandom_range(12), FLAW_NONE));
         else if (r < 75)
            send_frame(build_frame($urandom_range(12),
                                   flaw_type'($urandom_range(FLAW_DEV, FLAW_HEAD))));
         else if (r < 85)
            send_frame(build_frame($urandom_range(5, 1), FLAW_NOISE));
         else if (r < 95)
            send_frame(build_frame($urandom_range(20, 6), FLAW_NOISE));
         else
            send_frame(build_frame($urandom_range(72, 56), FLAW_NONE));
         progress = bytes_sent - start;
      end
      calm = 1'b0;
   endtask

   // result side ready, with one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin : check_words
      rfd_pkg::rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind       = rsp_tuser;
         got.data_byte  = rsp_tdata[7:0];
         got.addr       = rsp_tdata[15:8];
         got.code       = rsp_tdata[23:16];
         got.err_byte   = rsp_tdata[31:24];
         got.data_count = rsp_tdata[38:32];
         got.status     = rfd_pkg::status_type'(rsp_tdata[41:39]);
         if (deframed_words.size() == 0) begin
            report_mismatch("unexpected word", '0, {rsp_tuser, rsp_tdata});
         end else begin
            want = deframed_words.pop_front();
            if (got.kind !== want.kind) report_mismatch("kind", want.kind, got.kind);
            if (got.data_byte !== want.data_byte)
               report_mismatch("data_byte", want.data_byte, got.data_byte);
            if (got.addr !== want.addr) report_mismatch("addr", want.addr, got.addr);
            if (got.code !== want.code) report_mismatch("code", want.code, got.code);
            if (got.err_byte !== want.err_byte)
               report_mismatch("err_byte", want.err_byte, got.err_byte);
            if (got.data_count !== want.data_count)
               report_mismatch("data_count", want.data_count, got.data_count);
            if (got.status !== want.status)
               report_mismatch("status", want.status, got.status);
         end
      end
   end

   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_registers();
      test_frame_status();
      test_overlong();
      test_backpressure();
      test_random();
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### sim.f
hdl/rfd_pkg.sv
hdl/rfd_csr.sv
hdl/rfd_tracker.sv
hdl/rfd_skid.sv
hdl/reply_frame_deframer.sv
tb/tb_reply_frame_deframer.sv
